FILE: src/pblru_pkg.sv
// Shared types and constants for the page buffer LRU lookup unit.
package pblru_pkg;
  localparam int NumFrames = 64;
  localparam int MaxTables = 16;
  localparam int PageBits = 32;
  localparam int FrameW = $clog2(NumFrames + 1);
  localparam int AddrW = $clog2(NumFrames);
  localparam int CountW = FrameW;
  localparam int TableW = 5;
  localparam int PageW = 32;
  localparam int TagW = TableW + PageBits;

  typedef logic [FrameW-1:0] frame_t;

  typedef struct packed {
    logic clear;        // reset search pointer, latch request
    logic step;         // advance the search pointer
    logic take;         // latch the matching frame
    logic alloc;        // take a fresh frame
    logic evict;        // take the LRU head
    logic unlink;       // cut the selected frame out of the LRU list
    logic update;       // write tag, dirty and tail links, emit result
    logic reject;       // emit an all-zero result
  } pblru_cmd_t;

  typedef struct packed {
    logic bad_table;
    logic hit;          // current search entry matches
    logic scan_done;    // search passed the last allocated frame
    logic can_alloc;
  } pblru_sts_t;
endpackage

FILE: src/pblru_ctrl.sv
// Sequencer for the page buffer LRU lookup unit.
module pblru_ctrl import pblru_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  pblru_sts_t sts,
  output pblru_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LREAD = 3'd3;
  localparam logic [2:0] S_LINK = 3'd4;
  localparam logic [2:0] S_UPDATE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.clear = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad_table) begin
          cmd.reject = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.step = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.take = 1'b1;
          state_next = S_LREAD;
        end else if (sts.scan_done) begin
          if (sts.can_alloc) cmd.alloc = 1'b1;
          else cmd.evict = 1'b1;
          state_next = S_LREAD;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_LREAD: state_next = S_LINK;
      S_LINK: begin
        cmd.unlink = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

FILE: src/pblru_dp.sv
// Tag store, dirty bits, LRU links and result registers.
module pblru_dp import pblru_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  pblru_cmd_t        cmd,
  output pblru_sts_t        sts,
  input  logic [TableW-1:0] table_num,
  input  logic [PageW-1:0]  page_num,
  input  logic              mark_dirty,
  input  logic [6:0]        limit_reg,
  output logic              done,
  output logic [6:0]        frame_index,
  output logic              was_hit,
  output logic              victim_valid,
  output logic [4:0]        victim_table,
  output logic [31:0]       victim_page,
  output logic              victim_write_back
);
  // frame f lives at address f-1; no entry's value is used before it is written
  logic [TagW-1:0] tags [0:NumFrames-1];
  logic dirty [0:NumFrames-1];
  frame_t prev_l [0:NumFrames-1];
  frame_t next_l [0:NumFrames-1];
  frame_t head, tail;
  logic [CountW-1:0] allocated;

  logic [TableW-1:0] req_table;
  logic [PageBits-1:0] req_page;
  logic req_dirty;
  frame_t ptr, tag_ptr, sel, hv, prev_q, next_q;
  logic found, v_valid, vwb_q, unlink_ok;
  logic [TagW-1:0] tag_q;
  logic [CountW-1:0] limit;
  logic [AddrW-1:0] ptr_a, sel_a, hv_a;
  logic nx_we, pv_we;
  logic [AddrW-1:0] nx_a, pv_a;
  frame_t nx_d, pv_d;

  assign limit = (limit_reg == '0) ? CountW'(1)
               : (limit_reg > 7'(NumFrames)) ? CountW'(NumFrames) : CountW'(limit_reg);

  assign hv = (head == '0) ? frame_t'(1) : head;
  assign ptr_a = AddrW'(ptr - frame_t'(1));
  assign sel_a = AddrW'(sel - frame_t'(1));
  assign hv_a = AddrW'(hv - frame_t'(1));

  assign sts.bad_table = (req_table == '0) || (req_table > TableW'(MaxTables));
  assign sts.hit = (tag_ptr <= allocated) && (tag_q == {req_table, req_page});
  assign sts.scan_done = (tag_ptr > allocated);
  assign sts.can_alloc = (allocated < limit);

  // a freshly allocated frame is not on the list yet
  assign unlink_ok = (head != '0) && (tail != sel) && (found || v_valid);

  always_comb begin
    nx_we = 1'b0;
    nx_a = '0;
    nx_d = '0;
    pv_we = 1'b0;
    pv_a = '0;
    pv_d = '0;
    if (cmd.unlink && unlink_ok) begin
      if (prev_q != '0) begin
        nx_we = 1'b1;
        nx_a = AddrW'(prev_q - frame_t'(1));
        nx_d = next_q;
      end
      if (next_q != '0) begin
        pv_we = 1'b1;
        pv_a = AddrW'(next_q - frame_t'(1));
        pv_d = prev_q;
      end
    end
    if (cmd.update) begin
      if (head == '0) begin
        pv_we = 1'b1;
        pv_a = sel_a;
        pv_d = '0;
      end else if (tail != sel) begin
        // the tail's next link is never read, so it is left as is
        nx_we = 1'b1;
        nx_a = AddrW'(tail - frame_t'(1));
        nx_d = sel;
        pv_we = 1'b1;
        pv_a = sel_a;
        pv_d = tail;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_q <= tags[ptr_a];
    prev_q <= prev_l[sel_a];
    next_q <= next_l[sel_a];
    if (cmd.evict) vwb_q <= dirty[hv_a];
    if (cmd.update && !found) tags[sel_a] <= {req_table, req_page};
    if (cmd.update && (!found || req_dirty)) dirty[sel_a] <= req_dirty;
    if (nx_we) next_l[nx_a] <= nx_d;
    if (pv_we) prev_l[pv_a] <= pv_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      allocated <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.update | cmd.reject;
      tag_ptr <= ptr;
      if (cmd.clear) begin
        req_table <= table_num;
        req_page <= page_num[PageBits-1:0];
        req_dirty <= mark_dirty;
        ptr <= frame_t'(1);
        found <= 1'b0;
        v_valid <= 1'b0;
      end
      if (cmd.step) ptr <= ptr + frame_t'(1);
      if (cmd.take) begin
        found <= 1'b1;
        sel <= tag_ptr;
      end
      if (cmd.alloc) begin
        allocated <= allocated + CountW'(1);
        sel <= frame_t'(allocated + CountW'(1));
      end
      if (cmd.evict) begin
        // point the tag read at the victim so its tag is on hand at update
        sel <= hv;
        ptr <= hv;
        v_valid <= 1'b1;
      end
      if (cmd.unlink && unlink_ok && prev_q == '0) head <= next_q;
      if (cmd.update) begin
        if (head == '0) begin
          head <= sel;
          tail <= sel;
        end else if (tail != sel) begin
          tail <= sel;
        end
        frame_index <= 7'(sel);
        was_hit <= found;
        victim_valid <= v_valid;
        victim_table <= v_valid ? tag_q[TagW-1 -: TableW] : '0;
        victim_page <= v_valid ? 32'(tag_q[PageBits-1:0]) : '0;
        victim_write_back <= v_valid & vwb_q;
      end
      if (cmd.reject) begin
        frame_index <= '0;
        was_hit <= 1'b0;
        victim_valid <= 1'b0;
        victim_table <= '0;
        victim_page <= '0;
        victim_write_back <= 1'b0;
      end
    end
  end
endmodule

FILE: src/page_buffer_lru_lookup_unit.sv
// Top level of the page buffer LRU lookup unit.
// One access at a time: start is taken while busy is low; the result shows
// for one cycle under done and cannot be held off. The serial tag search
// runs one frame per cycle, and after it come the read and the two writes
// of the LRU links; a bad table skips both. done rises in the same cycle as
// busy falls, and the next start can be taken in that cycle.
// frames_in_use is written through cfg_valid/cfg_ready; the user must write it
// only while the unit is idle, as the block itself does not enforce it.
module page_buffer_lru_lookup_unit import pblru_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  table_num,
  input  logic [31:0] page_num,
  input  logic        mark_dirty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output logic        done,
  output logic [6:0]  frame_index,
  output logic        was_hit,
  output logic        victim_valid,
  output logic [4:0]  victim_table,
  output logic [31:0] victim_page,
  output logic        victim_write_back
);
  pblru_cmd_t cmd;
  pblru_sts_t sts;
  logic [6:0] frames_in_use;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) frames_in_use <= 7'd64;
    else if (cfg_valid && cfg_ready) frames_in_use <= cfg_data;
  end

  pblru_ctrl u_ctrl (.clk, .rst, .start, .busy, .sts, .cmd);

  pblru_dp u_dp (
    .clk, .rst, .cmd, .sts, .table_num, .page_num, .mark_dirty,
    .limit_reg(frames_in_use), .done, .frame_index, .was_hit,
    .victim_valid, .victim_table, .victim_page, .victim_write_back
  );

`ifndef SYNTHESIS
  a_hit_no_victim: assert property (@(posedge clk) disable iff (rst)
    done && was_hit |-> !victim_valid) else $error("hit with victim");
  a_wb_needs_victim: assert property (@(posedge clk) disable iff (rst)
    done && victim_write_back |-> victim_valid) else $error("write-back without victim");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without access");
`endif
endmodule

FILE: tb/tb_page_buffer_lru_lookup_unit.sv
// Self-checking testbench for the page buffer LRU lookup unit.
`timescale 1ns / 1ps

class lru_frame_scoreboard;
  typedef struct packed {
    logic [6:0]  frame;
    logic        hit;
    logic        vvalid;
    logic [4:0]  vtable;
    logic [31:0] vpage;
    logic        vwb;
  } lookup_res_t;

  int unsigned pool_limit;
  logic [4:0]  tag_table [1:64];
  logic [31:0] tag_page [1:64];
  bit          dirty [1:64];
  int unsigned prev_lnk [0:64];
  int unsigned next_lnk [0:64];
  int unsigned head, tail, allocated;
  lookup_res_t pending [$];
  int errors;

  function new();
    pool_limit = 64;
    head = 0;
    tail = 0;
    allocated = 0;
    errors = 0;
    for (int i = 0; i <= 64; i++) begin
      prev_lnk[i] = 0;
      next_lnk[i] = 0;
      if (i > 0) dirty[i] = 0;
    end
  endfunction

  function void set_limit(logic [6:0] v);
    pool_limit = v;
  endfunction

  function void promote(int unsigned f);
    int unsigned p, n;
    if (head == 0) begin
      head = f;
      tail = f;
      prev_lnk[f] = 0;
      next_lnk[f] = 0;
      return;
    end
    if (tail == f) return;
    p = prev_lnk[f];
    n = next_lnk[f];
    if (p != 0 || n != 0) begin
      if (p != 0) next_lnk[p] = n; else head = n;
      if (n != 0) prev_lnk[n] = p; else tail = p;
    end
    if (tail != 0) next_lnk[tail] = f; else head = f;
    prev_lnk[f] = tail;
    next_lnk[f] = 0;
    tail = f;
  endfunction

  function void note_access(logic [4:0] tid, logic [31:0] pg, logic md);
    lookup_res_t r;
    int unsigned lim, f;
    r = '0;
    if (tid == 0 || tid > 16) begin
      pending = {pending, r};
      return;
    end
    lim = pool_limit;
    if (lim < 1) lim = 1;
    if (lim > 64) lim = 64;
    f = 0;
    for (int i = 1; i <= allocated; i++) begin
      if (tag_table[i] == tid && tag_page[i] == pg) begin
        f = i;
        r.hit = 1;
        break;
      end
    end
    if (!r.hit) begin
      if (allocated < lim) begin
        allocated++;
        f = allocated;
      end else begin
        f = (head == 0) ? 1 : head;
        r.vvalid = 1;
        r.vtable = tag_table[f];
        r.vpage = tag_page[f];
        r.vwb = dirty[f];
      end
      dirty[f] = 0;
      tag_table[f] = tid;
      tag_page[f] = pg;
    end
    promote(f);
    if (md) dirty[f] = 1;
    r.frame = 7'(f);
    pending = {pending, r};
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task check_result(lookup_res_t got);
    lookup_res_t w;
    if (pending.size() == 0) begin
      report("unexpected result", got, 0);
      return;
    end
    w = pending.pop_front();
    if (got.frame !== w.frame) report("frame_index", got.frame, w.frame);
    if (got.hit !== w.hit) report("was_hit", got.hit, w.hit);
    if (got.vvalid !== w.vvalid) report("victim_valid", got.vvalid, w.vvalid);
    if (got.vtable !== w.vtable) report("victim_table", got.vtable, w.vtable);
    if (got.vpage !== w.vpage) report("victim_page", got.vpage, w.vpage);
    if (got.vwb !== w.vwb) report("victim_write_back", got.vwb, w.vwb);
  endtask
endclass

module tb_page_buffer_lru_lookup_unit;
  import pblru_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [4:0]  table_num = '0;
  logic [31:0] page_num = '0;
  logic        mark_dirty = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        done;
  logic [6:0]  frame_index;
  logic        was_hit;
  logic        victim_valid;
  logic [4:0]  victim_table;
  logic [31:0] victim_page;
  logic        victim_write_back;

  lru_frame_scoreboard pool;
  int  idle_cycles;
  bit  no_gaps;
  logic [31:0] recent_pages [8];

  page_buffer_lru_lookup_unit dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) pool.check_result({frame_index, was_hit, victim_valid,
                                         victim_table, victim_page, victim_write_back});
  end

  // watchdog: count cycles with no beat on any side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("tb_page_buffer_lru_lookup_unit: done, errors");
      $finish;
    end
  end

  // drop start and scramble the fields while idling
  task gap();
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 0;
      table_num <= $urandom;
      page_num <= $urandom;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // start stays high after the beat; the next call or drain() sets it
  task access(logic [4:0] tid, logic [31:0] pg, logic md);
    gap();
    start <= 1;
    table_num <= tid;
    page_num <= pg;
    mark_dirty <= md;
    do @(posedge clk); while (busy);
    pool.note_access(tid, pg, md);
  endtask

  task drain();
    start <= 0;
    while (pool.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task write_pool_size(logic [6:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    pool.set_limit(v);
    cfg_valid <= 0;
  endtask

  task random_access();
    logic [4:0]  tid;
    logic [31:0] pg;
    int k;
    k = $urandom_range(0, 99);
    if (k < 4) tid = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
    else tid = $urandom_range(1, 16);
    if (k < 45) pg = recent_pages[$urandom_range(0, 7)];
    else if (k < 85) pg = $urandom_range(0, 40);
    else pg = $urandom;
    if (tid > 4 && k < 70) tid = $urandom_range(1, 4);
    access(tid, pg, $urandom_range(0, 1));
    if ($urandom_range(0, 5) == 0) recent_pages[$urandom_range(0, 7)] = pg;
  endtask

  initial begin
    logic [6:0] sizes [6];
    pool = new();
    no_gaps = 0;
    sizes = '{7'd1, 7'd0, 7'd2, 7'd127, 7'd64, 7'd5};
    foreach (recent_pages[i]) recent_pages[i] = $urandom_range(0, 40);
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, bad tables, hit, dirty eviction
    access(5'd1, 32'h0, 1);
    access(5'd16, 32'hFFFF_FFFF, 0);
    access(5'd1, 32'h0, 0);
    access(5'd0, 32'h1234, 1);
    access(5'd17, 32'h1234, 1);
    access(5'd31, 32'hAAAA_5555, 0);
    access(5'd16, 32'h5555_AAAA, 1);
    write_pool_size(7'd0);
    access(5'd2, 32'h7, 1);
    access(5'd3, 32'h8, 0);
    access(5'd3, 32'h8, 0);
    write_pool_size(7'd3);
    for (int i = 0; i < 10; i++) access(5'd4 + (i % 3), i % 5, i[0]);

    foreach (sizes[s]) begin
      write_pool_size(sizes[s]);
      for (int i = 0; i < 220; i++) random_access();
    end
    write_pool_size(7'd8);
    no_gaps = 1;
    for (int i = 0; i < 100; i++) random_access();

    drain();
    if (pool.errors == 0) $display("tb_page_buffer_lru_lookup_unit: done, clean");
    else $display("tb_page_buffer_lru_lookup_unit: done, errors");
    $finish;
  end
endmodule
